[hdl/leb_pkg.sv]
// leb_pkg: command and result beat types, command codes and markers for the
// line edit buffer. No dependencies; imported by every leb module.
package leb_pkg;

    localparam int PTR_W   = 6;
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    localparam logic [3:0] FUNC_PUT      = 4'd0;
    localparam logic [3:0] FUNC_BKSP     = 4'd1;
    localparam logic [3:0] FUNC_DEL      = 4'd2;
    localparam logic [3:0] FUNC_TOGGLE   = 4'd3;
    localparam logic [3:0] FUNC_LEFT     = 4'd4;
    localparam logic [3:0] FUNC_RIGHT    = 4'd5;
    localparam logic [3:0] FUNC_HOME     = 4'd6;
    localparam logic [3:0] FUNC_END      = 4'd7;
    localparam logic [3:0] FUNC_CLRALL   = 4'd8;
    localparam logic [3:0] FUNC_CLREOL   = 4'd9;
    localparam logic [3:0] FUNC_SHOW     = 4'd10;

    localparam logic [7:0] MARK_INSERT    = 8'h5F;
    localparam logic [7:0] MARK_OVERWRITE = 8'h7C;

    typedef struct packed {
        logic [3:0] func;
        logic [7:0] char_in;
    } cmd_t;

    typedef struct packed {
        logic [7:0]       char_out;
        logic [PTR_W-1:0] text_length;
        logic [PTR_W-1:0] cursor_pos;
        logic             insert_mode;
        logic             full_drop;
        logic             last;
    } rsp_t;

    typedef enum logic [3:0] {
        OP_PUT,
        OP_BKSP,
        OP_DEL,
        OP_TOGGLE,
        OP_LEFT,
        OP_RIGHT,
        OP_HOME,
        OP_END,
        OP_CLRALL,
        OP_CLREOL,
        OP_SHOW,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
    } work_t;

endpackage

[hdl/leb_front.sv]
// leb_front: takes command beats and classifies them into decoded work items.
// Depends on leb_pkg; feeds leb_queue.
module leb_front (
    input  leb_pkg::cmd_t  cmd,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  logic           q_ready,
    output logic           q_push,
    output leb_pkg::work_t q_item
);
    import leb_pkg::*;

    op_t op;

    always_comb
    begin
        case (cmd.func)
            FUNC_PUT:    op = OP_PUT;
            FUNC_BKSP:   op = OP_BKSP;
            FUNC_DEL:    op = OP_DEL;
            FUNC_TOGGLE: op = OP_TOGGLE;
            FUNC_LEFT:   op = OP_LEFT;
            FUNC_RIGHT:  op = OP_RIGHT;
            FUNC_HOME:   op = OP_HOME;
            FUNC_END:    op = OP_END;
            FUNC_CLRALL: op = OP_CLRALL;
            FUNC_CLREOL: op = OP_CLREOL;
            FUNC_SHOW:   op = OP_SHOW;
            default:     op = OP_NOP;
        endcase
    end

    assign cmd_stall   = !q_ready;
    assign q_push      = cmd_valid && q_ready;
    assign q_item.op   = op;
    assign q_item.ch   = cmd.char_in;

endmodule

[hdl/leb_queue.sv]
// leb_queue: two-entry work queue between the front and back parts.
// Depends on leb_pkg.
module leb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  leb_pkg::work_t push_item,
    output logic           ready,
    input  logic           pop,
    output logic           valid,
    output leb_pkg::work_t head
);
    import leb_pkg::*;

    work_t             slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_AW:0]     count_reg;
    logic [Q_AW-1:0]   wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_next;
    logic [Q_AW:0]     count_next;
    logic              do_push;
    logic              do_pop;

    assign ready   = (count_reg != (Q_AW+1)'(Q_DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[hdl/leb_back.sv]
// leb_back: executes work items on the text store and drives result beats.
// Depends on leb_pkg; holds the text memory and the output register.
module leb_back #(
    parameter int CAPACITY = 63
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  leb_pkg::work_t q_item,
    output logic           q_pop,
    output leb_pkg::rsp_t  rsp,
    output logic           rsp_valid,
    input  logic           rsp_stall
);
    import leb_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [PTR_W-1:0] CAP = PTR_W'(CAPACITY);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SHIFT,
        ST_INS_WRITE,
        ST_DEL_SHIFT,
        ST_SHOW_RD,
        ST_SHOW_OUT,
        ST_STATUS
    } state_t;

    logic [7:0] mem [CAPACITY];
    logic [7:0] rdata_reg;

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] len_reg, len_next;
    logic [PTR_W-1:0] cur_reg, cur_next;
    logic             ovw_reg, ovw_next;
    logic [PTR_W-1:0] idx_reg, idx_next;
    logic [PTR_W-1:0] src_reg, src_next;
    logic [PTR_W-1:0] dst_reg, dst_next;
    logic             rd_act_reg, rd_act_next;
    logic             wr_pend_reg, wr_pend_next;
    logic [7:0]       ch_reg, ch_next;
    logic             drop_reg, drop_next;
    rsp_t             rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [7:0]       mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic             slot_free;
    logic [PTR_W-1:0] show_addr;

    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    // stored index for show position: text before the marker is at idx, after it at idx-1
    always_comb
    begin
        if (idx_reg > cur_reg)
        begin
            show_addr = idx_reg - 1'b1;
        end
        else if (idx_reg < cur_reg)
        begin
            show_addr = idx_reg;
        end
        else
        begin
            show_addr = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        cur_next       = cur_reg;
        ovw_next       = ovw_reg;
        idx_next       = idx_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        rd_act_next    = rd_act_reg;
        wr_pend_next   = wr_pend_reg;
        ch_next        = ch_reg;
        drop_next      = drop_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mem_we         = 1'b0;
        mem_waddr      = dst_reg[AW-1:0];
        mem_wdata      = rdata_reg;
        mem_raddr      = src_reg[AW-1:0];
        q_pop          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    ch_next      = q_item.ch;
                    drop_next    = 1'b0;
                    wr_pend_next = 1'b0;
                    state_next   = ST_STATUS;
                    case (q_item.op)
                        OP_PUT:
                        begin
                            if (ovw_reg && (cur_reg < len_reg))
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cur_reg[AW-1:0];
                                mem_wdata = q_item.ch;
                                cur_next  = cur_reg + 1'b1;
                            end
                            else if (len_reg >= CAP)
                            begin
                                drop_next = 1'b1;
                            end
                            else if (len_reg > cur_reg)
                            begin
                                src_next    = len_reg - 1'b1;
                                rd_act_next = 1'b1;
                                state_next  = ST_INS_SHIFT;
                            end
                            else
                            begin
                                state_next = ST_INS_WRITE;
                            end
                        end
                        OP_BKSP:
                        begin
                            if (cur_reg != '0)
                            begin
                                cur_next = cur_reg - 1'b1;
                                len_next = len_reg - 1'b1;
                                if (cur_reg < len_reg)
                                begin
                                    src_next    = cur_reg;
                                    rd_act_next = 1'b1;
                                    state_next  = ST_DEL_SHIFT;
                                end
                            end
                        end
                        OP_DEL:
                        begin
                            if (cur_reg < len_reg)
                            begin
                                len_next = len_reg - 1'b1;
                                if ((cur_reg + 1'b1) < len_reg)
                                begin
                                    src_next    = cur_reg + 1'b1;
                                    rd_act_next = 1'b1;
                                    state_next  = ST_DEL_SHIFT;
                                end
                            end
                        end
                        OP_TOGGLE:
                        begin
                            ovw_next = !ovw_reg;
                        end
                        OP_LEFT:
                        begin
                            if (cur_reg != '0)
                            begin
                                cur_next = cur_reg - 1'b1;
                            end
                        end
                        OP_RIGHT:
                        begin
                            if (cur_reg < len_reg)
                            begin
                                cur_next = cur_reg + 1'b1;
                            end
                        end
                        OP_HOME:
                        begin
                            cur_next = '0;
                        end
                        OP_END:
                        begin
                            cur_next = len_reg;
                        end
                        OP_CLRALL:
                        begin
                            len_next = '0;
                            cur_next = '0;
                        end
                        OP_CLREOL:
                        begin
                            if (cur_reg < len_reg)
                            begin
                                len_next = cur_reg;
                            end
                        end
                        OP_SHOW:
                        begin
                            idx_next   = '0;
                            state_next = ST_SHOW_RD;
                        end
                        default:
                        begin
                            state_next = ST_STATUS;
                        end
                    endcase
                end
            end
            // read walks down from the tail, each read word lands one place higher
            ST_INS_SHIFT:
            begin
                mem_we       = wr_pend_reg;
                wr_pend_next = rd_act_reg;
                if (rd_act_reg)
                begin
                    dst_next = src_reg + 1'b1;
                    if (src_reg == cur_reg)
                    begin
                        rd_act_next = 1'b0;
                    end
                    else
                    begin
                        src_next = src_reg - 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_INS_WRITE;
                end
            end
            ST_INS_WRITE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = cur_reg[AW-1:0];
                mem_wdata  = ch_reg;
                len_next   = len_reg + 1'b1;
                cur_next   = cur_reg + 1'b1;
                state_next = ST_STATUS;
            end
            // read walks up to the old tail, each read word lands one place lower
            ST_DEL_SHIFT:
            begin
                mem_we       = wr_pend_reg;
                wr_pend_next = rd_act_reg;
                if (rd_act_reg)
                begin
                    dst_next = src_reg - 1'b1;
                    if (src_reg == len_reg)
                    begin
                        rd_act_next = 1'b0;
                    end
                    else
                    begin
                        src_next = src_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_STATUS;
                end
            end
            ST_SHOW_RD:
            begin
                mem_raddr  = show_addr[AW-1:0];
                state_next = ST_SHOW_OUT;
            end
            ST_SHOW_OUT:
            begin
                // keep the read data steady while the output slot is busy
                mem_raddr = show_addr[AW-1:0];
                if (slot_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.char_out    = (idx_reg == cur_reg)
                                         ? (ovw_reg ? MARK_OVERWRITE : MARK_INSERT)
                                         : rdata_reg;
                    rsp_next.text_length = len_reg;
                    rsp_next.cursor_pos  = cur_reg;
                    rsp_next.insert_mode = !ovw_reg;
                    rsp_next.full_drop   = 1'b0;
                    rsp_next.last        = (idx_reg == len_reg);
                    if (idx_reg == len_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SHOW_RD;
                    end
                end
            end
            ST_STATUS:
            begin
                if (slot_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.char_out    = '0;
                    rsp_next.text_length = len_reg;
                    rsp_next.cursor_pos  = cur_reg;
                    rsp_next.insert_mode = !ovw_reg;
                    rsp_next.full_drop   = drop_reg;
                    rsp_next.last        = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            cur_reg       <= '0;
            ovw_reg       <= 1'b0;
            idx_reg       <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            rd_act_reg    <= 1'b0;
            wr_pend_reg   <= 1'b0;
            ch_reg        <= '0;
            drop_reg      <= 1'b0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cur_reg       <= cur_next;
            ovw_reg       <= ovw_next;
            idx_reg       <= idx_next;
            src_reg       <= src_next;
            dst_reg       <= dst_next;
            rd_act_reg    <= rd_act_next;
            wr_pend_reg   <= wr_pend_next;
            ch_reg        <= ch_next;
            drop_reg      <= drop_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

endmodule

[hdl/line_edit_buffer_top.sv]
// line_edit_buffer_top: one-line edit buffer with cursor and insert/overwrite mode.
// Depends on leb_pkg, leb_front, leb_queue and leb_back.
//
//   channel   direction   handshake               beat
//   cmd       in          cmd_valid / cmd_stall   leb_pkg::cmd_t  (func, char_in)
//   rsp       out         rsp_valid / rsp_stall   leb_pkg::rsp_t  (status or shown char)
//
// a status command passes through dequeue, then output register load
// a put or erase inside the text moves each character in a shift state, then drains the last read
// show produces each result beat by a memory read, then an output register load
// the two-entry queue lets new commands enter while the back part is busy
// reset clears length, cursor and mode; text memory contents are not cleared
// a stalled output holds its beat; the back part waits and the queue backs up
module line_edit_buffer_top #(
    parameter int CAPACITY = 63
) (
    input  logic          clk,
    input  logic          rst_n,
    input  leb_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    output leb_pkg::rsp_t rsp,
    output logic          rsp_valid,
    input  logic          rsp_stall
);
    import leb_pkg::*;

    logic  q_ready;
    logic  q_push;
    work_t q_in;
    logic  q_valid;
    logic  q_pop;
    work_t q_head;

    leb_front u_front (
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_item    (q_in)
    );

    leb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    leb_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_head),
        .q_pop     (q_pop),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

endmodule
